// ===== design/fmpf_pkg.sv =====
// Package: opcodes, status codes, counter selects and rule record type.
package fmpf_pkg;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_DECIDE = 3'd3,
        OP_COUNT  = 3'd4,
        OP_STAT   = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam int unsigned NUM_CNT = 7;
    localparam logic [2:0] C_FLOWS    = 3'd0;
    localparam logic [2:0] C_ALLOWED  = 3'd1;
    localparam logic [2:0] C_DENIED   = 3'd2;
    localparam logic [2:0] C_INVALID  = 3'd3;
    localparam logic [2:0] C_ADDED    = 3'd4;
    localparam logic [2:0] C_REMOVED  = 3'd5;
    localparam logic [2:0] C_REJECTED = 3'd6;

    localparam int unsigned IN_BITS  = 3 + 2 + 3 + 2 + 1 + 16 + 16 + 32 + 32 + 16 + 32 + 3;
    localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
    localparam int unsigned OUT_BITS = 2 + 1 + 5 + 5 + 32;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    // rule fields shared by the match unit and the controller
    typedef struct packed {
        logic        dir;
        logic [1:0]  proto;
        logic        est;
        logic [15:0] plo;
        logic [15:0] phi;
        logic [31:0] ilo;
        logic [31:0] ihi;
    } t_rule_key;

    typedef struct packed {
        logic [1:0]  dir;
        logic [2:0]  proto;
        logic        est;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] sip;
        logic [31:0] dip;
    } t_flow;

endpackage

// ===== design/fmpf_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module fmpf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/fmpf_match.sv =====
// Rule-versus-flow match check for one rule read from the table.
module fmpf_match #(
    parameter int unsigned APP_TAG_BITS = 16
) (
    input  fmpf_pkg::t_rule_key       i_key,
    input  logic [APP_TAG_BITS-1:0]   i_rule_app,
    input  fmpf_pkg::t_flow           i_flow,
    input  logic [APP_TAG_BITS-1:0]   i_flow_app,
    output logic                      o_match
);
    import fmpf_pkg::*;

    logic        outb;
    logic [15:0] port;
    logic [31:0] addr;
    logic        port_ok;
    logic        addr_ok;

    always_comb begin
        // ranges test the destination of an outbound flow, else the source
        outb = (i_flow.dir == 2'd1);
        port = outb ? i_flow.dport : i_flow.sport;
        addr = outb ? i_flow.dip : i_flow.sip;
        port_ok = ((i_key.plo == 16'd0) && (i_key.phi == 16'd0)) ||
                  ((port >= i_key.plo) && (port <= i_key.phi));
        addr_ok = ((i_key.ilo == 32'd0) && (i_key.ihi == 32'd0)) ||
                  ((addr >= i_key.ilo) && (addr <= i_key.ihi));
        o_match = (i_flow.dir == {1'b0, i_key.dir}) &&
                  ((i_key.proto == 2'd0) || ({1'b0, i_key.proto} == i_flow.proto)) &&
                  (!i_key.est || i_flow.est) && port_ok && addr_ok &&
                  ((i_rule_app == '0) || (i_rule_app == i_flow_app));
    end
endmodule

// ===== design/first_match_packet_filter.sv =====
// Top level: rule table in RAM, scan/shift sequencer, counters, output register.
// Paths: read-statistic and bad opcodes go from idle straight to output; append writes at entry used;
// rejected add or invalid flow ends after the first read; decide and count scan the rules
// (one table read per cycle, at most used); insert shifts every entry up, remove later ones down.
// Next request taken in the cycle after the result loads; hold in output state while one waits.
// Synchronous active-low reset clears count, statistics, sets id counter to 1; table RAM not cleared.
module first_match_packet_filter #(
    parameter int unsigned RULES        = 16,
    parameter int unsigned APP_TAG_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // opcode, direction, protocol, verdict_in, established_flag, port_a,
    // port_b, ip_a, ip_b, app_tag, target_id, stat_select
    input  logic [fmpf_pkg::IN_BYTES*8-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status, allowed, match_count, entries_used, stat_value
    output logic [fmpf_pkg::OUT_BYTES*8-1:0]     m_axis_tdata
);
    import fmpf_pkg::*;

    localparam int unsigned AW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int unsigned CW = $clog2(RULES + 1);
    localparam int unsigned RW = 32 + 64 + 32 + 5 + APP_TAG_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SHRD  = 7'b0001000,
        S_SHWR  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // unpacked request fields
    logic [2:0]  f_op;
    logic [1:0]  f_dir;
    logic [2:0]  f_proto;
    logic [1:0]  f_act;
    logic        f_est;
    logic [15:0] f_pa, f_pb;
    logic [31:0] f_ia, f_ib;
    logic [15:0] f_app;
    logic [31:0] f_tid;
    logic [2:0]  f_sel;

    assign f_op    = s_axis_tdata[2:0];
    assign f_dir   = s_axis_tdata[4:3];
    assign f_proto = s_axis_tdata[7:5];
    assign f_act   = s_axis_tdata[9:8];
    assign f_est   = s_axis_tdata[10];
    assign f_pa    = s_axis_tdata[26:11];
    assign f_pb    = s_axis_tdata[42:27];
    assign f_ia    = s_axis_tdata[74:43];
    assign f_ib    = s_axis_tdata[106:75];
    assign f_app   = s_axis_tdata[122:107];
    assign f_tid   = s_axis_tdata[154:123];
    assign f_sel   = s_axis_tdata[157:155];

    // held request
    logic [2:0]              r_op;
    logic [1:0]              r_dir;
    logic [2:0]              r_proto;
    logic                    r_act, r_est;
    logic [15:0]             r_pa, r_pb;
    logic [31:0]             r_ia, r_ib;
    logic [APP_TAG_BITS-1:0] r_app;
    logic [31:0]             r_tid;

    logic [CW-1:0]  r_used;
    logic [31:0]    r_idc;
    logic [31:0]    r_cnt [NUM_CNT];
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_rdidx;   // index of entry whose data arrives this cycle
    logic           r_found, r_allow;
    logic [CW-1:0]  r_mcnt;
    logic [1:0]     r_status;
    logic [31:0]    r_sval;
    logic           r_oval;
    logic [OUT_BITS-1:0] r_odata;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [RW-1:0]  ram_wdata, ram_rdata;
    logic [RW-1:0]  new_rule;

    fmpf_ram #(.WIDTH(RW), .DEPTH(RULES)) u_tab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // record: app, est, act, proto, dir, id, ihi, ilo, phi, plo
    t_rule_key               key;
    logic [APP_TAG_BITS-1:0] rapp;
    logic                    ract;
    logic [31:0]             rid;
    t_flow                   flow;
    logic                    hit;

    always_comb begin
        key.plo   = ram_rdata[15:0];
        key.phi   = ram_rdata[31:16];
        key.ilo   = ram_rdata[63:32];
        key.ihi   = ram_rdata[95:64];
        rid       = ram_rdata[127:96];
        key.dir   = ram_rdata[128];
        key.proto = ram_rdata[130:129];
        ract      = ram_rdata[131];
        key.est   = ram_rdata[132];
        rapp      = ram_rdata[RW-1:133];
        flow.dir    = r_dir;
        flow.proto  = r_proto;
        flow.est    = r_est;
        flow.sport  = r_pa;
        flow.dport  = r_pb;
        flow.sip    = r_ia;
        flow.dip    = r_ib;
        new_rule  = {r_app, r_est, r_act, r_proto[1:0], r_dir[0], r_idc,
                     r_ib, r_ia, r_pb, r_pa};
    end

    logic flow_outb_match;
    fmpf_match #(.APP_TAG_BITS(APP_TAG_BITS)) u_match (
        .i_key      (key),
        .i_rule_app (rapp),
        .i_flow     (flow),
        .i_flow_app (r_app),
        .o_match    (flow_outb_match)
    );
    // match unit compares the zero-extended rule direction against the flow's full direction field
    assign hit = flow_outb_match;

    logic tmpl_bad, flow_bad, full;
    assign tmpl_bad = r_dir[1] || r_proto[2] || (r_pa > r_pb) || (r_ia > r_ib);
    assign flow_bad = r_dir[1] || ((r_pa == 16'd0) && (r_pb == 16'd0) && r_dir[0] &&
                      (r_proto != 3'd0) && (r_proto != 3'd3));
    assign full = (r_used >= CW'(RULES));

    logic out_load;
    // load the output register when it is free or being drained this cycle
    assign out_load = (r_state == S_OUT) && (!r_oval || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, r_odata};

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = new_rule;
        ram_raddr = r_idx[AW-1:0];
        case (r_state)
            S_SHWR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_waddr = (r_op == OP_INSERT) ? AW'(r_rdidx + CW'(1))
                                                : AW'(r_rdidx - CW'(1));
            end
            S_FIN: begin
                ram_we    = (r_op == OP_APPEND || r_op == OP_INSERT) && !r_found;
                ram_waddr = (r_op == OP_INSERT) ? '0 : r_used[AW-1:0];
            end
            default: ;
        endcase
    end

    // write enable above uses r_found as "rejected" flag for adds; keep decode here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_idc   <= 32'd1;
            r_oval  <= 1'b0;
            for (int k = 0; k < NUM_CNT; k++) r_cnt[k] <= '0;
        end else begin
            if (out_load) r_oval <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op <= f_op; r_dir <= f_dir; r_proto <= f_proto;
                        r_act <= f_act[0]; r_est <= f_est;
                        r_pa <= f_pa; r_pb <= f_pb; r_ia <= f_ia; r_ib <= f_ib;
                        r_app <= APP_TAG_BITS'(f_app);
                        r_tid <= f_tid;
                        r_found <= 1'b0; r_allow <= 1'b0; r_mcnt <= '0;
                        r_status <= ST_OK; r_sval <= '0;
                        r_idx <= '0;
                        r_state <= S_RD;
                        if (f_act[1]) r_proto <= 3'd4; // fold bad action into template check
                        if (f_op == OP_STAT) begin
                            if (f_sel >= 3'(NUM_CNT)) r_status <= ST_INVALID;
                            else r_sval <= r_cnt[f_sel];
                            r_state <= S_OUT;
                        end else if (f_op > OP_STAT) begin
                            r_status <= ST_INVALID;
                            r_state <= S_OUT;
                        end
                        if (f_op == OP_DECIDE || f_op == OP_COUNT) r_proto <= f_proto;
                    end
                end
                S_RD: begin
                    // first read issued (r_idx = 0); decide path for adds
                    r_rdidx <= r_idx;
                    r_idx   <= r_idx + CW'(1);
                    if (r_op == OP_APPEND || r_op == OP_INSERT) begin
                        if (tmpl_bad) begin
                            r_status <= ST_INVALID; r_found <= 1'b1;
                            r_cnt[C_REJECTED] <= r_cnt[C_REJECTED] + 32'd1;
                            r_state <= S_OUT;
                        end else if (full) begin
                            r_status <= ST_FULL; r_found <= 1'b1;
                            r_cnt[C_REJECTED] <= r_cnt[C_REJECTED] + 32'd1;
                            r_state <= S_OUT;
                        end else if (r_op == OP_INSERT && r_used != '0) begin
                            r_idx <= r_used - CW'(1);
                            r_state <= S_SHRD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (r_op == OP_DECIDE && flow_bad) begin
                        r_status <= ST_INVALID;
                        r_cnt[C_INVALID] <= r_cnt[C_INVALID] + 32'd1;
                        r_state <= S_OUT;
                    end else if (r_used == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // data for r_rdidx is valid now
                    r_rdidx <= r_idx;
                    r_idx   <= r_idx + CW'(1);
                    if (r_found) begin
                        // remove: shift entry r_rdidx down one
                        r_state <= S_SHRD;
                        r_idx   <= r_rdidx;
                    end else if (r_op == OP_REMOVE && rid == r_tid) begin
                        r_found <= 1'b1;
                        if (r_rdidx + CW'(1) >= r_used) r_state <= S_FIN;
                        else begin
                            r_idx <= r_rdidx + CW'(1);
                            r_state <= S_SHRD;
                        end
                    end else if (r_op == OP_DECIDE && hit) begin
                        r_found <= 1'b1; r_allow <= ract;
                        r_state <= S_FIN;
                    end else begin
                        if (r_op == OP_COUNT && hit) r_mcnt <= r_mcnt + CW'(1);
                        if (r_rdidx + CW'(1) >= r_used) r_state <= S_FIN;
                    end
                end
                S_SHRD: begin
                    // read issued at r_idx; data next cycle
                    r_rdidx <= r_idx;
                    r_state <= S_SHWR;
                end
                S_SHWR: begin
                    if (r_op == OP_INSERT) begin
                        if (r_rdidx == '0) r_state <= S_FIN;
                        else begin
                            r_idx <= r_rdidx - CW'(1);
                            r_state <= S_SHRD;
                        end
                    end else begin
                        if (r_rdidx + CW'(1) >= r_used) r_state <= S_FIN;
                        else begin
                            r_idx <= r_rdidx + CW'(1);
                            r_state <= S_SHRD;
                        end
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                    if (r_op == OP_APPEND || r_op == OP_INSERT) begin
                        r_used <= r_used + CW'(1);
                        r_idc  <= r_idc + 32'd1;
                        r_cnt[C_ADDED] <= r_cnt[C_ADDED] + 32'd1;
                    end else if (r_op == OP_REMOVE) begin
                        if (r_found) begin
                            r_used <= r_used - CW'(1);
                            r_cnt[C_REMOVED] <= r_cnt[C_REMOVED] + 32'd1;
                        end else r_status <= ST_NOTFOUND;
                    end else if (r_op == OP_DECIDE) begin
                        r_cnt[C_FLOWS] <= r_cnt[C_FLOWS] + 32'd1;
                        if (r_allow) r_cnt[C_ALLOWED] <= r_cnt[C_ALLOWED] + 32'd1;
                        else         r_cnt[C_DENIED]  <= r_cnt[C_DENIED] + 32'd1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_odata <= {r_sval, 5'(r_used), 5'(r_mcnt),
                                    (r_op == OP_DECIDE) & r_allow & (r_status == ST_OK),
                                    r_status};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== verif/first_match_packet_filter_tb.sv =====
// Testbench for the first-match packet filter: directed and random rule traffic checked by a scoreboard.
`timescale 1ns / 1ps

module first_match_packet_filter_tb;
    import fmpf_pkg::*;

    localparam int unsigned RULES = 16;
    localparam int unsigned IN_W  = IN_BYTES * 8;
    localparam int unsigned OUT_W = OUT_BYTES * 8;
    localparam longint LIMIT = 400000;

    typedef struct {
        logic [2:0]  op;
        logic [1:0]  dir;
        logic [2:0]  proto;
        logic [1:0]  verdict;
        logic        est;
        logic [15:0] port_a;
        logic [15:0] port_b;
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        logic [15:0] app;
        logic [31:0] tid;
        logic [2:0]  sel;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic        allowed;
        logic [4:0]  mcount;
        logic [4:0]  used;
        logic [31:0] stat;
    } t_resp;

    typedef struct {
        logic [15:0] plo, phi;
        logic [31:0] ilo, ihi;
        logic [31:0] id;
        logic        dir;
        logic [1:0]  proto;
        logic        verdict;
        logic        est;
        logic [15:0] app;
    } t_rule;

    class filter_scoreboard;
        t_rule       table_q[$];
        logic [31:0] next_id;
        logic [31:0] stats[NUM_CNT];
        t_resp       pending[$];
        int          errors;

        function new();
            next_id = 1;
            errors = 0;
            foreach (stats[k]) stats[k] = 0;
        endfunction

        function bit hits(t_rule r, t_req q);
            logic [15:0] p;
            logic [31:0] a;
            p = (q.dir == 1) ? q.port_b : q.port_a;
            a = (q.dir == 1) ? q.ip_b : q.ip_a;
            if ({1'b0, r.dir} != q.dir) return 0;
            if (r.proto != 0 && {1'b0, r.proto} != q.proto) return 0;
            if (r.est && !q.est) return 0;
            if ((r.plo != 0 || r.phi != 0) && (p < r.plo || p > r.phi)) return 0;
            if ((r.ilo != 0 || r.ihi != 0) && (a < r.ilo || a > r.ihi)) return 0;
            if (r.app != 0 && r.app != q.app) return 0;
            return 1;
        endfunction

        function void note_request(t_req q);
            t_resp e;
            t_rule r;
            int found;
            e = '{ST_OK, 1'b0, 5'd0, 5'd0, 32'd0};
            case (q.op)
                OP_APPEND, OP_INSERT: begin
                    if (q.dir > 1 || q.proto > 3 || q.verdict > 1 || q.port_a > q.port_b
                        || q.ip_a > q.ip_b) begin
                        stats[C_REJECTED]++;
                        e.status = ST_INVALID;
                    end else if (table_q.size() >= RULES) begin
                        stats[C_REJECTED]++;
                        e.status = ST_FULL;
                    end else begin
                        r = '{q.port_a, q.port_b, q.ip_a, q.ip_b, next_id, q.dir[0],
                              q.proto[1:0], q.verdict[0], q.est, q.app};
                        if (q.op == OP_INSERT) table_q.push_front(r);
                        else table_q.push_back(r);
                        next_id++;
                        stats[C_ADDED]++;
                    end
                end
                OP_REMOVE: begin
                    found = -1;
                    foreach (table_q[k])
                        if (found < 0 && table_q[k].id == q.tid) found = k;
                    if (found < 0) e.status = ST_NOTFOUND;
                    else begin
                        table_q.delete(found);
                        stats[C_REMOVED]++;
                    end
                end
                OP_DECIDE: begin
                    if (q.dir > 1 || (q.port_a == 0 && q.port_b == 0 && q.dir == 1
                        && q.proto != 0 && q.proto != 3)) begin
                        stats[C_INVALID]++;
                        e.status = ST_INVALID;
                    end else begin
                        stats[C_FLOWS]++;
                        found = 0;
                        foreach (table_q[k])
                            if (!found && hits(table_q[k], q)) begin
                                found = 1;
                                e.allowed = table_q[k].verdict;
                            end
                        if (e.allowed) stats[C_ALLOWED]++;
                        else stats[C_DENIED]++;
                    end
                end
                OP_COUNT: foreach (table_q[k]) if (hits(table_q[k], q)) e.mcount++;
                OP_STAT: begin
                    if (q.sel < NUM_CNT) e.stat = stats[q.sel];
                    else e.status = ST_INVALID;
                end
                default: e.status = ST_INVALID;
            endcase
            e.used = 5'(table_q.size());
            pending.push_back(e);
        endfunction

        function void check_response(t_resp a);
            t_resp e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response %p", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status != e.status || a.allowed != e.allowed || a.mcount != e.mcount
                || a.used != e.used || a.stat != e.stat) begin
                $display("%0t: mismatch expected %p actual %p", $time, e, a);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             s_axis_tvalid = 0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;

    filter_scoreboard sb;
    longint           cycle = 0;
    bit               stall_on = 1;

    first_match_packet_filter dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall pattern, sometimes always ready
    always @(negedge i_clk)
        m_axis_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_response('{m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[7:3],
                                m_axis_tdata[12:8], m_axis_tdata[44:13]});

    function automatic logic [IN_W-1:0] pack_req(t_req q);
        return IN_W'({q.sel, q.tid, q.app, q.ip_b, q.ip_a, q.port_b, q.port_a, q.est,
                      q.verdict, q.proto, q.dir, q.op});
    endfunction

    task automatic send_request(t_req q);
        s_axis_tdata <= pack_req(q);
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(q);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    function automatic t_req rand_req();
        t_req q;
        int   pick;
        q.op = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick < 3) q.op = OP_DECIDE;
        else if (pick < 5) q.op = OP_COUNT;
        else if (pick < 8) q.op = 3'($urandom_range(0, 2));
        q.dir = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, 1));
        q.proto = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
        q.verdict = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1));
        q.est = 1'($urandom);
        q.port_a = 16'($urandom);
        q.port_b = 16'($urandom);
        q.ip_a = $urandom;
        q.ip_b = $urandom;
        if (q.op <= OP_INSERT) begin
            // mostly well-formed ranges, some wildcards, a few inverted
            if ($urandom_range(0, 3) == 0) begin q.port_a = 0; q.port_b = 0; end
            else if (q.port_a > q.port_b && $urandom_range(0, 7) != 0)
                {q.port_a, q.port_b} = {q.port_b, q.port_a};
            if ($urandom_range(0, 3) == 0) begin q.ip_a = 0; q.ip_b = 0; end
            else if (q.ip_a > q.ip_b && $urandom_range(0, 7) != 0)
                {q.ip_a, q.ip_b} = {q.ip_b, q.ip_a};
        end else if ($urandom_range(0, 15) == 0) begin
            q.port_a = 0;
            q.port_b = 0;
        end
        q.app = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
        q.tid = ($urandom_range(0, 5) == 0) ? $urandom : 32'($urandom_range(1, sb.next_id));
        q.sel = 3'($urandom_range(0, 7));
        return q;
    endfunction

    initial begin
        t_req q;
        int   burst;
        int   n;
        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: extremes, every opcode, invalid templates and flows, full table
        q = '{OP_STAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, C_FLOWS};
        send_request(q);
        q = '{OP_DECIDE, 1, 0, 0, 1, 80, 80, 1, 2, 0, 0, 0};
        send_request(q);
        q = '{OP_APPEND, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'hFFFF, 32'hFFFF_FFFF, 7};
        send_request(q);
        q = '{OP_APPEND, 3, 7, 3, 0, 0, 0, 0, 0, 0, 0, 0};
        send_request(q);
        q = '{OP_APPEND, 0, 0, 0, 0, 5, 4, 0, 0, 0, 0, 0};
        send_request(q);
        q = '{OP_INSERT, 0, 0, 0, 0, 0, 0, 9, 8, 0, 0, 0};
        send_request(q);
        q = '{OP_DECIDE, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_request(q);
        q = '{OP_DECIDE, 2, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0};
        send_request(q);
        q = '{OP_COUNT, 3, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
        send_request(q);
        q = '{OP_DECIDE, 1, 1, 0, 1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'hFFFF, 0, 0};
        send_request(q);
        q = '{OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd77, 0};
        send_request(q);
        q = '{OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd1, 0};
        send_request(q);
        for (int k = 0; k < RULES + 1; k++) begin
            q = '{OP_INSERT, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
            send_request(q);
        end
        q = '{OP_COUNT, 0, 1, 0, 0, 3, 4, 5, 6, 0, 0, 0};
        send_request(q);
        q = '{3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_request(q);
        q = '{OP_STAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd7};
        send_request(q);
        for (int k = 0; k < RULES; k++) begin
            q = '{OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'(k + 3), 0};
            send_request(q);
        end

        // random bursts with gaps; the receiver stalls in phases
        n = 0;
        while (n < 1400) begin
            burst = $urandom_range(1, 20);
            if ($urandom_range(0, 9) == 0) stall_on = !stall_on;
            for (int k = 0; k < burst; k++) begin
                send_request(rand_req());
                n++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end
        s_axis_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
